// ===== rtl/r10u_pkg.sv =====
`timescale 1ns / 1ps

package r10u_pkg;

  // Field and state widths
  localparam int PixelBits = 10;
  localparam int ByteW     = 8;
  localparam int BufW      = 17;
  localparam int CntW      = 5;
  localparam int CfgDimW   = 13;
  localparam int StrideW   = 14;
  localparam int IndexW    = 24;

  // Stride is saturated to this many bytes
  localparam int StrideLimit = 8192;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 14;

  // Register reset values
  localparam logic [CfgDimW-1:0] WidthReset  = 13'd1920;
  localparam logic [CfgDimW-1:0] HeightReset = 13'd1080;
  localparam logic [StrideW-1:0] StrideReset = 14'd2400;

  // Default size limits
  localparam int DefMaxWidth  = 4096;
  localparam int DefMaxHeight = 4096;

  // Work queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = 1;
  localparam int QCntW      = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_STRIDE    = 2'd2,
    REG_TRANSPOSE = 2'd3
  } cfg_reg_e;

  // Saturated frame geometry as seen by both halves
  typedef struct packed {
    logic [CfgDimW-1:0] width;
    logic [CfgDimW-1:0] height;
    logic               transpose;
  } geom_t;

  // One queue entry: an optional pixel and an optional row-start reload
  typedef struct packed {
    logic                 has_pix;
    logic [PixelBits-1:0] pix;
    logic                 row_end;
    logic                 frame_end;
    logic                 short_row;
    logic                 reload;
    logic [CfgDimW-1:0]   row_next;
  } work_t;

endpackage

// ===== rtl/r10u_ifs.sv =====
`timescale 1ns / 1ps

// Packed byte stream
interface r10u_byte_if import r10u_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Unpacked pixel stream
interface r10u_pixel_if import r10u_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PixelBits-1:0] pixel_value;
  logic [IndexW-1:0]    dest_index;
  logic                 row_end;
  logic                 frame_end;
  logic                 short_row;

  modport source (output valid, output pixel_value, output dest_index, output row_end,
                  output frame_end, output short_row, input ready);
  modport sink   (input valid, input pixel_value, input dest_index, input row_end,
                  input frame_end, input short_row, output ready);
endinterface

// Register write channel
interface r10u_cfg_if import r10u_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/r10u_front.sv =====
`timescale 1ns / 1ps

module r10u_front import r10u_pkg::*; #(
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  geom_t              geom_i,
  input  logic [StrideW-1:0] stride_i,
  r10u_byte_if.sink          byte_i,
  input  logic               full_i,
  output logic               push_o,
  output work_t              work_o
);

  localparam int HLim = (MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT;
  localparam int RowW = (HLim > 2) ? $clog2(HLim) : 1;

  logic [BufW-1:0]    buf_q, buf_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CfgDimW-1:0] col_q, col_d;
  logic [CfgDimW-1:0] bir_q, bir_d;
  logic [RowW-1:0]    row_q, row_d;

  logic               accept;
  logic               last_byte;
  logic               active;
  logic [BufW-1:0]    merged;
  logic [CntW-1:0]    cnt_sum;
  logic [CfgDimW-1:0] col_inc;
  logic [CfgDimW-1:0] row_plus;
  logic               row_wrap;
  logic [CfgDimW-1:0] row_next;
  logic               have;
  logic               partial;
  logic [PixelBits-1:0] pix;
  logic               shrt;
  logic               rend;

  assign byte_i.ready = !full_i;
  assign accept       = byte_i.valid && !full_i;

  // Row bookkeeping
  assign last_byte = ({1'b0, bir_q} + StrideW'(1)) >= stride_i;
  assign active    = col_q < geom_i.width;
  assign col_inc   = col_q + CfgDimW'(1);
  assign row_plus  = CfgDimW'(row_q) + CfgDimW'(1);
  assign row_wrap  = row_plus >= geom_i.height;
  assign row_next  = row_wrap ? '0 : row_plus;

  // New byte lands above the bits already held
  assign merged  = buf_q | (BufW'(byte_i.data_byte) << cnt_q);
  assign cnt_sum = cnt_q + CntW'(ByteW);

  always_comb begin
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    col_d   = col_q;
    bir_d   = bir_q + CfgDimW'(1);
    row_d   = row_q;
    have    = 1'b0;
    partial = 1'b0;
    pix     = '0;
    if (active) begin
      buf_d = merged;
      cnt_d = cnt_sum;
      if (cnt_sum >= CntW'(PixelBits)) begin
        pix   = merged[PixelBits-1:0];
        buf_d = merged >> PixelBits;
        cnt_d = cnt_sum - CntW'(PixelBits);
        have  = 1'b1;
      end else if (last_byte) begin
        // stride ran out: flush what is held, missing high bits as zero
        pix     = merged[PixelBits-1:0];
        have    = 1'b1;
        partial = 1'b1;
      end
      if (have) begin
        col_d = col_inc;
      end
    end
    if (last_byte) begin
      buf_d = '0;
      cnt_d = '0;
      col_d = '0;
      bir_d = '0;
      row_d = RowW'(row_next);
    end
  end

  assign shrt = have && (partial || (last_byte && (col_inc < geom_i.width)));
  assign rend = have && (shrt || (col_inc >= geom_i.width));

  // Queue entry
  assign push_o             = accept && (have || last_byte);
  assign work_o.has_pix     = have;
  assign work_o.pix         = pix;
  assign work_o.row_end     = rend;
  assign work_o.frame_end   = rend && row_wrap;
  assign work_o.short_row   = shrt;
  assign work_o.reload      = last_byte;
  assign work_o.row_next    = row_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
      col_q <= '0;
      bir_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
      col_q <= col_d;
      bir_q <= bir_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== rtl/r10u_fifo.sv =====
`timescale 1ns / 1ps

module r10u_fifo import r10u_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output work_t data_o
);

  work_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q;
  logic [QPtrW-1:0]  rd_ptr_q;
  logic [QCntW-1:0]  count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = count_q == QCntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/r10u_back.sv =====
`timescale 1ns / 1ps

module r10u_back import r10u_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  geom_t geom_i,
  input  logic  avail_i,
  input  work_t work_i,
  output logic  pop_o,
  r10u_pixel_if.source pixel_o
);

  logic [IndexW-1:0]      idx_q, idx_d;
  logic                   out_valid_q;
  logic [PixelBits-1:0]   pix_q;
  logic [IndexW-1:0]      dest_q;
  logic                   rend_q;
  logic                   fend_q;
  logic                   shrt_q;

  logic                   can_out;
  logic                   take_pix;
  logic [IndexW-1:0]      step;
  logic [2*CfgDimW-1:0]   row_base;

  assign can_out  = !out_valid_q || pixel_o.ready;
  assign pop_o    = avail_i && (!work_i.has_pix || can_out);
  assign take_pix = pop_o && work_i.has_pix;

  // Index stride per pixel and row start position
  assign step     = geom_i.transpose ? IndexW'(geom_i.height) : IndexW'(1);
  assign row_base = work_i.row_next * geom_i.width;

  always_comb begin
    idx_d = idx_q;
    if (take_pix) begin
      idx_d = idx_q + step;
    end
    if (pop_o && work_i.reload) begin
      idx_d = geom_i.transpose ? IndexW'(work_i.row_next) : row_base[IndexW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (take_pix) begin
        out_valid_q <= 1'b1;
      end else if (pixel_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (take_pix) begin
      pix_q  <= work_i.pix;
      dest_q <= idx_q;
      rend_q <= work_i.row_end;
      fend_q <= work_i.frame_end;
      shrt_q <= work_i.short_row;
    end
  end

  assign pixel_o.valid       = out_valid_q;
  assign pixel_o.pixel_value = pix_q;
  assign pixel_o.dest_index  = dest_q;
  assign pixel_o.row_end     = rend_q;
  assign pixel_o.frame_end   = fend_q;
  assign pixel_o.short_row   = shrt_q;

endmodule

// ===== rtl/raw10_lsb_pixel_unpacker.sv =====
`timescale 1ns / 1ps

// Unpacks a raw frame of 10-bit pixels packed LSB first (4 pixels in 5 bytes)
// from a byte stream and emits each pixel with its destination index, row-major
// or column-major. One byte is accepted per clock; the pixel that a byte completes
// goes through the queue and output register, and the byte rate holds as long as
// the pixel sink takes requests. The front end holds the bit buffer and the row
// counters, a two-entry queue sits between it and the back end, and the back end
// keeps the running index, reloading it at each row start through one
// 13x13 multiplier (row times width) that feeds the index register. Register
// writes are taken every cycle and act at once; write them only while the block
// is idle. Width, height and stride are saturated to their legal ranges, a zero
// counting as one.

module raw10_lsb_pixel_unpacker import r10u_pkg::*; #(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  r10u_cfg_if.sink     cfg_i,
  r10u_byte_if.sink    byte_i,
  r10u_pixel_if.source pixel_o
);

  localparam int WLim = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam int HLim = (MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT;

  logic [CfgDimW-1:0] width_q;
  logic [CfgDimW-1:0] height_q;
  logic [StrideW-1:0] stride_q;
  logic               transpose_q;

  geom_t              geom;
  logic [StrideW-1:0] stride;

  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               pop;
  work_t              work;
  work_t              q_data;

  // Register file
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WidthReset;
      height_q    <= HeightReset;
      stride_q    <= StrideReset;
      transpose_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.reg_index))
        REG_WIDTH:     width_q     <= cfg_i.wdata[CfgDimW-1:0];
        REG_HEIGHT:    height_q    <= cfg_i.wdata[CfgDimW-1:0];
        REG_STRIDE:    stride_q    <= cfg_i.wdata[StrideW-1:0];
        REG_TRANSPOSE: transpose_q <= cfg_i.wdata[0];
        default:       ;
      endcase
    end
  end

  // Saturate geometry
  always_comb begin
    if (width_q == '0) begin
      geom.width = CfgDimW'(1);
    end else if (width_q > CfgDimW'(WLim)) begin
      geom.width = CfgDimW'(WLim);
    end else begin
      geom.width = width_q;
    end
    if (height_q == '0) begin
      geom.height = CfgDimW'(1);
    end else if (height_q > CfgDimW'(HLim)) begin
      geom.height = CfgDimW'(HLim);
    end else begin
      geom.height = height_q;
    end
    geom.transpose = transpose_q;
    if (stride_q == '0) begin
      stride = StrideW'(1);
    end else if (stride_q > StrideW'(StrideLimit)) begin
      stride = StrideW'(StrideLimit);
    end else begin
      stride = stride_q;
    end
  end

  r10u_front #(
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .geom_i   (geom),
    .stride_i (stride),
    .byte_i   (byte_i),
    .full_i   (q_full),
    .push_o   (push),
    .work_o   (work)
  );

  r10u_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (work),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  r10u_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .geom_i  (geom),
    .avail_i (q_valid),
    .work_i  (q_data),
    .pop_o   (pop),
    .pixel_o (pixel_o)
  );

endmodule

// ===== rtl/r10u_checker.sv =====
`timescale 1ns / 1ps

module r10u_checker import r10u_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [PixelBits-1:0] pixel_value_i,
  input logic [IndexW-1:0]    dest_index_i,
  input logic                 row_end_i,
  input logic                 frame_end_i,
  input logic                 short_row_i
);

  // A stalled pixel request keeps its value, index and row end flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_value_i)
      && $stable(dest_index_i) && $stable(row_end_i))
    else $error("pixel request changed while stalled");

  // The frame can only end on the last pixel of a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> row_end_i)
    else $error("frame end without row end");

  // A truncated row is always closed by its flagged pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && short_row_i |-> row_end_i)
    else $error("short row flag without row end");

endmodule

bind raw10_lsb_pixel_unpacker r10u_checker u_r10u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (pixel_o.valid),
  .out_ready_i   (pixel_o.ready),
  .pixel_value_i (pixel_o.pixel_value),
  .dest_index_i  (pixel_o.dest_index),
  .row_end_i     (pixel_o.row_end),
  .frame_end_i   (pixel_o.frame_end),
  .short_row_i   (pixel_o.short_row)
);

// ===== tb/tb_raw10_lsb_pixel_unpacker.sv =====
`timescale 1ns / 1ps

module tb_raw10_lsb_pixel_unpacker;
  import r10u_pkg::*;

  localparam int CycleLimit   = 600000;
  localparam int ItemTarget   = 1850;
  localparam int SettleCycles = 8;
  localparam int MaxReports   = 200;

  // One expected pixel request
  typedef struct packed {
    logic [PixelBits-1:0] pixel_value;
    logic [IndexW-1:0]    dest_index;
    logic                 row_end;
    logic                 frame_end;
    logic                 short_row;
  } pixel_t;

  // Directed stimulus: a geometry load or one byte, optionally with a typed-in result
  typedef struct {
    bit                  is_cfg;
    logic [CfgDataW-1:0] w_word;
    logic [CfgDataW-1:0] h_word;
    logic [CfgDataW-1:0] s_word;
    logic [CfgDataW-1:0] t_word;
    logic [ByteW-1:0]    data;
    bit                  typed;
    bit                  typed_has;
    pixel_t              typed_px;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  r10u_cfg_if   cfg_bus ();
  r10u_byte_if  byte_bus ();
  r10u_pixel_if pixel_bus ();

  raw10_lsb_pixel_unpacker DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_bus),
    .byte_i  (byte_bus),
    .pixel_o (pixel_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register shadow
  logic [CfgDimW-1:0] reg_width     = WidthReset;
  logic [CfgDimW-1:0] reg_height    = HeightReset;
  logic [StrideW-1:0] reg_stride    = StrideReset;
  logic               reg_transpose = 1'b0;

  // Unpacker state
  logic [BufW-1:0]    pk_buf     = '0;
  logic [CntW-1:0]    pk_bits    = '0;
  logic [CfgDimW-1:0] col_cnt    = '0;
  logic [CfgDimW-1:0] byte_pos   = '0;
  logic [11:0]        row_cnt    = '0;
  logic [IndexW-1:0]  next_index = '0;

  pixel_t    pixel_queue[$];
  stim_row_t directed_rows[$];
  int        mismatches  = 0;
  int        cycle_count = 0;
  bit        steady      = 1'b0;

  function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pixel_t mk_pixel(input int unsigned pix, input int unsigned idx,
                                      input bit re, input bit fe, input bit sr);
    pixel_t px;
    px.pixel_value = PixelBits'(pix);
    px.dest_index  = IndexW'(idx);
    px.row_end     = re;
    px.frame_end   = fe;
    px.short_row   = sr;
    return px;
  endfunction

  // Feeds one byte through the unpacker; returns 1 when it yields a pixel
  function automatic bit unpack_step(input logic [ByteW-1:0] value, output pixel_t px);
    int unsigned w, h, s;
    bit last, have, partial, consumed;
    w       = clamp_u(reg_width, 1, DefMaxWidth);
    h       = clamp_u(reg_height, 1, DefMaxHeight);
    s       = clamp_u(reg_stride, 1, StrideLimit);
    px      = '0;
    have    = 1'b0;
    partial = 1'b0;
    last    = (int'(byte_pos) + 1) >= s;
    consumed = col_cnt < w;

    if (consumed) begin
      pk_buf  = pk_buf | (BufW'(value) << pk_bits);
      pk_bits = pk_bits + 5'd8;
      if (pk_bits >= PixelBits) begin
        px.pixel_value = pk_buf[PixelBits-1:0];
        pk_buf  = pk_buf >> PixelBits;
        pk_bits = pk_bits - CntW'(PixelBits);
        have    = 1'b1;
      end else if (last) begin
        // stride ran out: emit the bits held so far, zero-extended
        px.pixel_value = pk_buf[PixelBits-1:0];
        have    = 1'b1;
        partial = 1'b1;
      end
      if (have) begin
        px.dest_index = next_index;
        next_index = next_index + (reg_transpose ? IndexW'(h) : IndexW'(1));
        col_cnt = col_cnt + 1'b1;
        if (partial || (last && col_cnt < w)) begin
          px.short_row = 1'b1;
          px.row_end   = 1'b1;
        end else if (col_cnt >= w) begin
          px.row_end = 1'b1;
        end
        if (px.row_end && (int'(row_cnt) + 1) >= h) px.frame_end = 1'b1;
      end
    end

    // row start: drop leftovers, advance row, reload index
    if (last) begin
      byte_pos = '0;
      pk_buf   = '0;
      pk_bits  = '0;
      col_cnt  = '0;
      row_cnt  = ((int'(row_cnt) + 1) >= h) ? '0 : row_cnt + 1'b1;
      next_index = reg_transpose ? IndexW'(row_cnt) : IndexW'(int'(row_cnt) * w);
    end else begin
      byte_pos = byte_pos + 1'b1;
    end
    return have;
  endfunction

  function automatic void add_cfg_row(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h,
                                      input logic [CfgDataW-1:0] s,
                                      input logic [CfgDataW-1:0] t);
    stim_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.w_word = w;
    row.h_word = h;
    row.s_word = s;
    row.t_word = t;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_byte_row(input logic [ByteW-1:0] data, input bit typed,
                                       input bit typed_has, input pixel_t typed_px);
    stim_row_t row;
    row           = '{default: '0};
    row.data      = data;
    row.typed     = typed;
    row.typed_has = typed_has;
    row.typed_px  = typed_px;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  // One register write request; valid stays high for a following write
  task automatic write_reg(input cfg_reg_e sel, input logic [CfgDataW-1:0] value);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= sel;
    cfg_bus.wdata     <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (sel)
      REG_WIDTH:     reg_width     = value[CfgDimW-1:0];
      REG_HEIGHT:    reg_height    = value[CfgDimW-1:0];
      REG_STRIDE:    reg_stride    = value[StrideW-1:0];
      REG_TRANSPOSE: reg_transpose = value[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_geometry(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h,
                               input logic [CfgDataW-1:0] s, input logic [CfgDataW-1:0] t);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_STRIDE, s);
    write_reg(REG_TRANSPOSE, t);
    cfg_bus.valid <= 1'b0;
  endtask

  // Drop byte valid, wait for every pixel, then let a byte with no pixel settle
  task automatic wait_idle();
    byte_bus.valid <= 1'b0;
    while (pixel_queue.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // One byte request; called and returns at a falling edge, valid left high
  task automatic send_byte(input logic [ByteW-1:0] value, input bit typed, input bit typed_has,
                           input pixel_t typed_px);
    pixel_t px;
    bit     has;
    while (!steady && $urandom_range(99) < 25) begin
      byte_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= value;
    do @(posedge clk_i); while (!byte_bus.ready);
    has = unpack_step(value, px);
    if (typed) begin
      if (typed_has) pixel_queue.push_back(typed_px);
    end else if (has) begin
      pixel_queue.push_back(px);
    end
    @(negedge clk_i);
  endtask

  // Pixel sink backpressure
  always @(negedge clk_i) begin
    pixel_bus.ready <= steady || ($urandom_range(99) >= 25);
  end

  // Pixel checker
  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && pixel_bus.valid && pixel_bus.ready) begin
      if (pixel_queue.size() == 0) begin
        report_mismatch("unexpected pixel request, pixel_value", pixel_bus.pixel_value, 0);
      end else begin
        want = pixel_queue.pop_front();
        if (pixel_bus.pixel_value !== want.pixel_value)
          report_mismatch("pixel_value", pixel_bus.pixel_value, want.pixel_value);
        if (pixel_bus.dest_index !== want.dest_index)
          report_mismatch("dest_index", pixel_bus.dest_index, want.dest_index);
        if (pixel_bus.row_end !== want.row_end)
          report_mismatch("row_end", pixel_bus.row_end, want.row_end);
        if (pixel_bus.frame_end !== want.frame_end)
          report_mismatch("frame_end", pixel_bus.frame_end, want.frame_end);
        if (pixel_bus.short_row !== want.short_row)
          report_mismatch("short_row", pixel_bus.short_row, want.short_row);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stim_row_t           row;
    int unsigned         random_items;
    int unsigned         phase;
    int unsigned         wv, hv, sv, need, nbytes;
    logic [CfgDataW-1:0] tw;
    logic [ByteW-1:0]    value;

    rst_ni              = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.reg_index   = REG_WIDTH;
    cfg_bus.wdata       = '0;
    byte_bus.valid      = 1'b0;
    byte_bus.data_byte  = '0;
    pixel_bus.ready     = 1'b0;

    // Reset geometry: all-ones bytes give full-scale pixels at indexes 0..3
    add_byte_row(8'hFF, 1'b1, 1'b0, '0);
    add_byte_row(8'hFF, 1'b1, 1'b1, mk_pixel(1023, 0, 0, 0, 0));
    add_byte_row(8'hFF, 1'b1, 1'b1, mk_pixel(1023, 1, 0, 0, 0));
    add_byte_row(8'hFF, 1'b1, 1'b1, mk_pixel(1023, 2, 0, 0, 0));
    add_byte_row(8'hFF, 1'b1, 1'b1, mk_pixel(1023, 3, 0, 0, 0));
    // One-byte rows, one-row frame: each byte after the first is a partial short row
    // (first byte lands mid-row after the geometry change and gives no pixel)
    add_cfg_row(14'd1, 14'd1, 14'd1, 14'd0);
    add_byte_row(8'hA5, 1'b0, 1'b0, '0);
    add_byte_row(8'h00, 1'b1, 1'b1, mk_pixel(8'h00, 0, 1, 1, 1));
    add_byte_row(8'hFF, 1'b1, 1'b1, mk_pixel(8'hFF, 0, 1, 1, 1));
    add_byte_row(8'h5A, 1'b1, 1'b1, mk_pixel(8'h5A, 0, 1, 1, 1));
    // Transposed, one padding byte per row, two-row frame
    add_cfg_row(14'd3, 14'd2, 14'd5, 14'd1);
    add_byte_row(8'h11, 1'b0, 1'b0, '0);
    add_byte_row(8'h22, 1'b0, 1'b0, '0);
    add_byte_row(8'h33, 1'b0, 1'b0, '0);
    add_byte_row(8'h44, 1'b0, 1'b0, '0);
    add_byte_row(8'h55, 1'b0, 1'b0, '0);
    add_byte_row(8'h66, 1'b0, 1'b0, '0);
    add_byte_row(8'h77, 1'b0, 1'b0, '0);
    add_byte_row(8'h88, 1'b0, 1'b0, '0);
    add_byte_row(8'h99, 1'b0, 1'b0, '0);
    add_byte_row(8'hAA, 1'b0, 1'b0, '0);
    // Short stride where the last byte completes a pixel
    add_cfg_row(14'd4, 14'd3, 14'd3, 14'd0);
    add_byte_row(8'hC3, 1'b0, 1'b0, '0);
    add_byte_row(8'h3C, 1'b0, 1'b0, '0);
    add_byte_row(8'h81, 1'b0, 1'b0, '0);
    add_byte_row(8'h7E, 1'b0, 1'b0, '0);
    add_byte_row(8'hE7, 1'b0, 1'b0, '0);
    add_byte_row(8'h18, 1'b0, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        load_geometry(row.w_word, row.h_word, row.s_word, row.t_word);
      end else begin
        send_byte(row.data, row.typed, row.typed_has, row.typed_px);
      end
    end

    // Random geometries, with a few extreme ones mixed in
    random_items = 0;
    phase        = 0;
    while (random_items < ItemTarget) begin
      steady = (phase >= 10 && phase < 14);
      tw = {CfgDimW'($urandom_range(0, 8191)), 1'($urandom_range(1))};
      wait_idle();
      case (phase)
        2: begin
          // width above range saturates to max, short rows at index row*width
          load_geometry(14'h3FFF, 14'd4096, 14'd40, 14'd0);
          nbytes = 200;
        end
        4: begin
          // zero registers count as one
          load_geometry(14'd0, 14'd0, 14'd0, 14'd1);
          nbytes = 20;
        end
        6: begin
          // stride above range saturates to max, row runs into padding
          load_geometry(14'd2, 14'd1, 14'h3FFF, 14'd0);
          nbytes = 40;
        end
        8: begin
          load_geometry(14'd4096, 14'd4096, 14'd16, 14'd1);
          nbytes = 64;
        end
        default: begin
          wv   = ($urandom_range(7) == 0) ? $urandom_range(13, 160) : $urandom_range(1, 12);
          need = (wv * PixelBits + 7) / 8;
          case ($urandom_range(19))
            0, 1, 2:       sv = $urandom_range(1, need);
            3, 4, 5, 6, 7: sv = need + $urandom_range(1, 4);
            default:       sv = need;
          endcase
          hv = (wv > 12) ? $urandom_range(1, 2) : $urandom_range(1, 6);
          load_geometry(CfgDataW'(wv), CfgDataW'(hv), CfgDataW'(sv), tw);
          nbytes = sv * hv * $urandom_range(1, 2) + $urandom_range(0, 3);
        end
      endcase
      repeat (nbytes) begin
        if (random_items >= ItemTarget) break;
        if ($urandom_range(9) == 0) value = $urandom_range(1) ? 8'hFF : 8'h00;
        else value = ByteW'($urandom_range(255));
        send_byte(value, 1'b0, 1'b0, '0);
        random_items++;
      end
      phase++;
    end

    steady = 1'b0;
    wait_idle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/r10u_pkg.sv
rtl/r10u_ifs.sv
rtl/r10u_front.sv
rtl/r10u_fifo.sv
rtl/r10u_back.sv
rtl/raw10_lsb_pixel_unpacker.sv
rtl/r10u_checker.sv
tb/tb_raw10_lsb_pixel_unpacker.sv
